### sv/tcgr_pkg.sv
// Package for the text console glyph renderer.
// Holds the transaction structs, the register indexes, the sizing constants and the
// row mask helper. It depends on nothing else.
`default_nettype none

package tcgr_pkg;

	// Sizing of the glyph store.
	localparam int MAX_GLYPHS      = 256;
	localparam int MAX_FONT_HEIGHT = 32;
	localparam int MAX_FONT_WIDTH  = 16;
	localparam int GLYPH_AW        = $clog2(MAX_GLYPHS);
	localparam int ROW_AW          = (MAX_FONT_HEIGHT > 1) ? $clog2(MAX_FONT_HEIGHT) : 1;
	localparam int STORE_AW        = GLYPH_AW + ROW_AW;
	localparam int STORE_DEPTH     = 2 ** STORE_AW;

	// Width of the cursor arithmetic: holds a cursor plus both advances and the margin.
	localparam int POS_W = 13;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PADDING       = 3'd5;

	// Operation codes.
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_PUT  = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Result kinds.
	localparam logic KIND_DRAW  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic [23:0] fg_color;
		logic [23:0] bg_color;
		logic [7:0]  glyph_index;
		logic [4:0]  glyph_row;
		logic [15:0] row_data;
		logic [11:0] new_x;
		logic [11:0] new_y;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [15:0] row_bits;
		logic [23:0] draw_fg;
		logic [23:0] draw_bg;
		logic        last;
	} out_item_t;

	// Request to the shared add and compare unit.
	typedef struct packed {
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		logic [POS_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [POS_W-1:0] sum;
		logic             ge;
	} alu_rsp_t;

	// Glyph store access.
	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] waddr;
		logic [15:0]         wdata;
		logic                re;
		logic [STORE_AW-1:0] raddr;
	} ram_req_t;

	// Sequencer to output stage.
	typedef struct packed {
		logic      push;
		logic      flush;
		out_item_t item;
	} out_req_t;

	typedef struct packed {
		logic can_push;
		logic flush_ok;
	} out_rsp_t;

	// Mask of the low min(font_width, MAX_FONT_WIDTH) bits of a glyph row.
	function automatic logic [15:0] row_mask(input logic [4:0] fw);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			m[i] = (i < MAX_FONT_WIDTH) && (5'(i) < fw);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### sv/tcgr_alu.sv
// Shared add and compare unit of the glyph renderer.
// Uses tcgr_pkg for the request and response structs.
`default_nettype none

module tcgr_alu (
	input  tcgr_pkg::alu_req_t req,
	output tcgr_pkg::alu_rsp_t rsp
);
	import tcgr_pkg::*;

	// One add, then a compare of the sum against the third operand.
	always_comb begin
		rsp.sum = req.a + req.b;
		rsp.ge  = (rsp.sum >= req.c);
	end

endmodule

`default_nettype wire

### sv/tcgr_glyph_ram.sv
// Glyph row store: one write port and one registered read port.
// Uses tcgr_pkg for the store size and the access struct.
`default_nettype none

module tcgr_glyph_ram (
	input  wire               clk,
	input  tcgr_pkg::ram_req_t req,
	output logic [15:0]       rdata
);
	import tcgr_pkg::*;

	logic [15:0] mem [STORE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Read port; the data holds while no read is requested.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

### sv/tcgr_out.sv
// Output stage: one pending result and the output register.
// The pending slot lets the final result of a transaction be marked last.
// Uses tcgr_pkg for the result struct and the request and response structs.
`default_nettype none

module tcgr_out (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tcgr_pkg::out_req_t  req,
	output tcgr_pkg::out_rsp_t  rsp,
	output logic                out_valid,
	input  wire                 out_stall,
	output tcgr_pkg::out_item_t out_data
);
	import tcgr_pkg::*;

	out_item_t pend_q;
	logic      pend_valid_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      load_out;
	logic      flush_move;
	out_item_t out_nx;

	assign out_free   = !out_valid_q || !out_stall;
	assign flush_move = req.flush && pend_valid_q && out_free;
	assign load_out   = (req.push && pend_valid_q) || flush_move;

	assign rsp.can_push = !pend_valid_q || out_free;
	assign rsp.flush_ok = !pend_valid_q || out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The pending result moves out; a flush marks it as the last one.
	always_comb begin
		out_nx      = pend_q;
		out_nx.last = flush_move;
	end

	// Valid flags of the pending slot and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (req.push) begin
				pend_valid_q <= 1'b1;
			end else if (flush_move) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: a new result moves the pending one out; a flush marks it last.
	always_ff @(posedge clk) begin
		if (req.push) begin
			pend_q <= req.item;
		end
		if (load_out) begin
			out_q <= out_nx;
		end
	end

	// A result is only offered when the pending slot can take it.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> rsp.can_push)
		else $error("result pushed with no room");

	// A flush of a pending result ends the transaction with a last result.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		flush_move |=> (out_valid_q && out_q.last && !pend_valid_q))
		else $error("flush did not deliver a last result");

	// A result pushed behind a pending one never carries the last mark.
	a_push_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && pend_valid_q) |=> (out_valid_q && !out_q.last))
		else $error("intermediate result marked last");

endmodule

`default_nettype wire

### sv/tcgr_ctrl.sv
// Sequencer of the glyph renderer: configuration registers, cursor, bounds check
// steps and the glyph row loop, all driving the shared add and compare unit.
// Uses tcgr_pkg for structs, codes and constants.
`default_nettype none

module tcgr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  tcgr_pkg::in_item_t  in_data,
	input  wire                 wr_en,
	input  wire [tcgr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire [tcgr_pkg::CFG_DATA_W-1:0] wr_data,
	output tcgr_pkg::alu_req_t  alu_req,
	input  tcgr_pkg::alu_rsp_t  alu_rsp,
	output tcgr_pkg::ram_req_t  ram_req,
	input  wire [15:0]          ram_rdata,
	output tcgr_pkg::out_req_t  out_req,
	input  tcgr_pkg::out_rsp_t  out_rsp
);
	import tcgr_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_NL   = 13'b0000000000010,
		S_X1   = 13'b0000000000100,
		S_X2   = 13'b0000000001000,
		S_X3   = 13'b0000000010000,
		S_X4   = 13'b0000000100000,
		S_Y1   = 13'b0000001000000,
		S_Y2   = 13'b0000010000000,
		S_Y3   = 13'b0000100000000,
		S_RD0  = 13'b0001000000000,
		S_ROW  = 13'b0010000000000,
		S_ADV  = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [8:0]  glyph_count_q;
	logic [4:0]  font_width_q;
	logic [5:0]  font_height_q;
	logic [11:0] screen_width_q;
	logic [11:0] screen_height_q;
	logic [7:0]  padding_q;

	// Working registers.
	logic [POS_W-1:0]    cur_x_q;
	logic [POS_W-1:0]    cur_y_q;
	logic [POS_W-1:0]    tmp_q;
	logic                second_q;
	logic [GLYPH_AW-1:0] glyph_q;
	logic [23:0]         fg_q;
	logic [23:0]         bg_q;
	logic [5:0]          cnt_q;

	logic [5:0]       rows;
	logic [5:0]       cnt_nx;
	logic [POS_W-1:0] pad_w;
	logic             accept;
	logic             char_ok;
	logic             load_ok;
	logic             check_done;
	state_t           after_check;

	assign pad_w    = POS_W'(padding_q);
	assign rows     = (font_height_q < 6'(MAX_FONT_HEIGHT)) ? font_height_q
	                                                         : 6'(MAX_FONT_HEIGHT);
	assign cnt_nx   = cnt_q + 6'd1;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	// Glyph selection and load range checks.
	assign char_ok = (in_data.char_code != 8'd0)
	                 && ({1'b0, in_data.char_code} < glyph_count_q)
	                 && ({1'b0, in_data.char_code} < 9'(MAX_GLYPHS));
	assign load_ok = ({1'b0, in_data.glyph_index} < 9'(MAX_GLYPHS))
	                 && ({1'b0, in_data.glyph_row} < 6'(MAX_FONT_HEIGHT));

	// The last bounds check step finishes here; the next step depends on the operation.
	assign check_done = ((state_q == S_Y2) && alu_rsp.ge && out_rsp.can_push)
	                    || ((state_q == S_Y3));
	always_comb begin
		if (second_q) begin
			after_check = S_FIN;
		end else if (rows == 6'd0) begin
			after_check = S_ADV;
		end else begin
			after_check = S_RD0;
		end
	end

	// Operands of the shared unit for each step.
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_NL, S_X3: begin
				alu_req.a = cur_y_q;
				alu_req.b = POS_W'(font_height_q);
			end
			S_X1: begin
				alu_req.a = pad_w;
				alu_req.b = POS_W'(font_width_q);
			end
			S_X2: begin
				alu_req.a = cur_x_q;
				alu_req.b = tmp_q;
				alu_req.c = POS_W'(screen_width_q);
			end
			S_X4: begin
				alu_req.a = pad_w;
				alu_req.c = cur_x_q;
			end
			S_Y1: begin
				alu_req.a = pad_w;
				alu_req.b = POS_W'(font_height_q);
			end
			S_Y2: begin
				alu_req.a = cur_y_q;
				alu_req.b = tmp_q;
				alu_req.c = POS_W'(screen_height_q);
			end
			S_Y3: begin
				alu_req.a = cur_y_q;
				alu_req.c = pad_w;
			end
			S_ROW: begin
				alu_req.a = cur_y_q;
				alu_req.b = POS_W'(cnt_q);
			end
			S_ADV: begin
				alu_req.a = cur_x_q;
				alu_req.b = POS_W'(font_width_q);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// Glyph store access: loads on accept, row reads during the row loop.
	always_comb begin
		ram_req       = '0;
		ram_req.we    = accept && (in_data.op == OP_LOAD) && load_ok;
		ram_req.waddr = {in_data.glyph_index[GLYPH_AW-1:0], in_data.glyph_row[ROW_AW-1:0]};
		ram_req.wdata = in_data.row_data;
		if (state_q == S_RD0) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = {glyph_q, {ROW_AW{1'b0}}};
		end else if (state_q == S_ROW) begin
			ram_req.re    = out_rsp.can_push;
			ram_req.raddr = {glyph_q, cnt_nx[ROW_AW-1:0]};
		end
	end

	// Results: a clear from the bottom check or one glyph row per step of the loop.
	always_comb begin
		out_req       = '0;
		out_req.flush = (state_q == S_FIN);
		if (state_q == S_Y2) begin
			out_req.push      = alu_rsp.ge && out_rsp.can_push;
			out_req.item.kind = KIND_CLEAR;
		end else if (state_q == S_ROW) begin
			out_req.push          = out_rsp.can_push;
			out_req.item.kind     = KIND_DRAW;
			out_req.item.pixel_x  = cur_x_q[11:0];
			out_req.item.pixel_y  = alu_rsp.sum[11:0];
			out_req.item.row_bits = ram_rdata & row_mask(font_width_q);
			out_req.item.draw_fg  = fg_q;
			out_req.item.draw_bg  = bg_q;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q   <= 9'd256;
			font_width_q    <= 5'd8;
			font_height_q   <= 6'd16;
			screen_width_q  <= 12'd1024;
			screen_height_q <= 12'd768;
			padding_q       <= 8'd10;
		end else if (wr_en) begin
			case (wr_index)
				REG_GLYPH_COUNT:   glyph_count_q   <= wr_data[8:0];
				REG_FONT_WIDTH:    font_width_q    <= wr_data[4:0];
				REG_FONT_HEIGHT:   font_height_q   <= wr_data[5:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= wr_data[11:0];
				REG_SCREEN_HEIGHT: screen_height_q <= wr_data[11:0];
				REG_PADDING:       padding_q       <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_x_q  <= POS_W'(10);
			cur_y_q  <= POS_W'(10);
			tmp_q    <= '0;
			second_q <= 1'b0;
			glyph_q  <= '0;
			fg_q     <= '0;
			bg_q     <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_data.op)
							OP_PUT: begin
								fg_q <= in_data.fg_color;
								bg_q <= in_data.bg_color;
								if (in_data.char_code == NEWLINE_CODE) begin
									cur_x_q  <= pad_w;
									second_q <= 1'b1;
									state_q  <= S_NL;
								end else begin
									glyph_q  <= char_ok ? in_data.char_code[GLYPH_AW-1:0]
									                    : '0;
									second_q <= 1'b0;
									state_q  <= S_X1;
								end
							end
							OP_SET: begin
								cur_x_q  <= POS_W'(in_data.new_x);
								cur_y_q  <= POS_W'(in_data.new_y);
								second_q <= 1'b1;
								state_q  <= S_X1;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_NL: begin
					cur_y_q <= alu_rsp.sum;
					state_q <= S_X1;
				end
				S_X1: begin
					tmp_q   <= alu_rsp.sum;
					state_q <= S_X2;
				end
				S_X2: begin
					// Right edge: wrap to the next line.
					if (alu_rsp.ge) begin
						cur_x_q <= pad_w;
						state_q <= S_X3;
					end else begin
						state_q <= S_X4;
					end
				end
				S_X3: begin
					cur_y_q <= alu_rsp.sum;
					state_q <= S_Y1;
				end
				S_X4: begin
					// Left edge clamp.
					if (alu_rsp.ge) begin
						cur_x_q <= pad_w;
					end
					state_q <= S_Y1;
				end
				S_Y1: begin
					tmp_q   <= alu_rsp.sum;
					state_q <= S_Y2;
				end
				S_Y2: begin
					// Bottom edge: clear the screen and home the cursor.
					if (alu_rsp.ge) begin
						if (out_rsp.can_push) begin
							cur_x_q <= pad_w;
							cur_y_q <= pad_w;
							state_q <= after_check;
						end
					end else begin
						state_q <= S_Y3;
					end
				end
				S_Y3: begin
					// Top edge clamp.
					if (!alu_rsp.ge) begin
						cur_y_q <= pad_w;
					end
					state_q <= after_check;
				end
				S_RD0: begin
					cnt_q   <= '0;
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (out_rsp.can_push) begin
						cnt_q <= cnt_nx;
						if (cnt_nx == rows) begin
							state_q <= S_ADV;
						end
					end
				end
				S_ADV: begin
					cur_x_q  <= alu_rsp.sum;
					second_q <= 1'b1;
					state_q  <= S_X1;
				end
				S_FIN: begin
					if (out_rsp.flush_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A put always starts a bounds check.
	a_put_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_data.op == OP_PUT)) |=> (state_q == S_NL || state_q == S_X1))
		else $error("put did not start a bounds check");

	// The row loop never runs past the font height.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> (cnt_q < rows))
		else $error("row counter past font height");

	// After a completed bounds check the cursor fits the 12-bit screen range.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		check_done |=> (cur_x_q[POS_W-1] == 1'b0 && cur_y_q[POS_W-1] == 1'b0))
		else $error("cursor out of range after bounds check");

endmodule

`default_nettype wire

### sv/text_console_glyph_renderer.sv
// Text console glyph renderer: top level.
// Instantiates tcgr_ctrl, tcgr_alu, tcgr_glyph_ram and tcgr_out; uses tcgr_pkg.
//
// Usage:
//  The input channel (in_valid, in_stall, in_data) takes one operation per
//  transaction: load a glyph row, put a character or set the cursor. The output
//  channel (out_valid, out_stall, out_data) delivers draw-row and clear-screen
//  results; last marks the final result of each input transaction.
//  The configuration port (wr_en, wr_index, wr_data) writes one register per
//  cycle; the user must use it only while the block is idle (not enforced).
//  A glyph row load is written on accept. A put of a printable character runs
//  a bounds check, the row loop over rows (font height, at most 32) and a second
//  check; a newline and a set cursor run one. A bounds check is six steps of
//  the shared add and compare unit, five when it clears; the row loop reads one
//  glyph store entry per cycle while the output can take results.
//  Results pass through a pending slot and an output register; a stalled
//  receiver holds the output and, once the pending slot is full as well,
//  holds the sequencer. in_stall is high while an operation is in progress.
//  Reset: configuration registers return to their defaults, the cursor goes to
//  the default padding, and no result is pending. The glyph store is not
//  cleared; rows must be loaded before they are drawn.
`default_nettype none

module text_console_glyph_renderer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  tcgr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output tcgr_pkg::out_item_t out_data,
	input  wire                 wr_en,
	input  wire [tcgr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire [tcgr_pkg::CFG_DATA_W-1:0] wr_data
);
	import tcgr_pkg::*;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	ram_req_t    ram_req;
	logic [15:0] ram_rdata;
	out_req_t    out_req;
	out_rsp_t    out_rsp;

	// Sequencer with cursor and configuration.
	tcgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.out_req   (out_req),
		.out_rsp   (out_rsp)
	);

	// Shared add and compare unit.
	tcgr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Glyph row store.
	tcgr_glyph_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Pending result and output register.
	tcgr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (out_req),
		.rsp       (out_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### sim/text_console_glyph_renderer_tb.sv
// Self-checking testbench for text_console_glyph_renderer.
// Depends on tcgr_pkg and the renderer RTL; it predicts every draw and clear
// transaction from its own model of the cursor, the glyph store and the registers.
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;
	import tcgr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_PAUSE = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_CAP  = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	// Shadow registers, cursor and glyph store of the predictor.
	int cfg_glyph_count = 256;
	int cfg_font_width = 8;
	int cfg_font_height = 16;
	int cfg_screen_width = 1024;
	int cfg_screen_height = 768;
	int cfg_padding = 10;
	int cur_x = 10;
	int cur_y = 10;
	logic [15:0] glyph_rows [STORE_DEPTH];
	bit row_loaded [STORE_DEPTH];

	// Draw and clear transactions still owed by the block, oldest first.
	out_item_t pending_draws[$];

	int err_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int unsigned cycle_count = 0;

	text_console_glyph_renderer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Glyph selected by a character: zero and out-of-range codes fall back to glyph 0.
	function automatic int glyph_for(input logic [7:0] c);
		if (c > 0 && int'(c) < cfg_glyph_count && int'(c) < MAX_GLYPHS) begin
			return int'(c);
		end
		return 0;
	endfunction

	function automatic int drawn_rows();
		return (cfg_font_height < MAX_FONT_HEIGHT) ? cfg_font_height : MAX_FONT_HEIGHT;
	endfunction

	// Random character for traffic: zero or the top code, which is in or out of
	// range depending on the glyph count.
	function automatic logic [7:0] pick_code();
		return ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
	endfunction

	// Bounds check: wrap at the right edge, clamp left and top, clear at the bottom.
	function automatic void fit_cursor();
		int right_lim;
		int bottom_lim;
		out_item_t d;
		right_lim = cfg_screen_width - (cfg_padding + cfg_font_width);
		bottom_lim = cfg_screen_height - (cfg_padding + cfg_font_height);
		if (cur_x >= right_lim) begin
			cur_x = cfg_padding;
			cur_y += cfg_font_height;
		end else if (cur_x <= cfg_padding) begin
			cur_x = cfg_padding;
		end
		if (cur_y >= bottom_lim) begin
			d = '0;
			d.kind = KIND_CLEAR;
			pending_draws.push_back(d);
			cur_x = cfg_padding;
			cur_y = cfg_padding;
		end else if (cur_y < cfg_padding) begin
			cur_y = cfg_padding;
		end
		cur_x &= 'hFFF;
		cur_y &= 'hFFF;
	endfunction

	// Works out the transactions that one accepted operation causes.
	function automatic void render_op(input in_item_t it);
		int start;
		int addr;
		int g;
		int fw_eff;
		int mask;
		out_item_t d;
		start = pending_draws.size();
		case (it.op)
			OP_LOAD: begin
				addr = int'(it.glyph_index) * MAX_FONT_HEIGHT + int'(it.glyph_row);
				if (int'(it.glyph_index) < MAX_GLYPHS && int'(it.glyph_row) < MAX_FONT_HEIGHT) begin
					glyph_rows[addr] = it.row_data;
					row_loaded[addr] = 1'b1;
				end
			end
			OP_PUT: begin
				if (it.char_code == NEWLINE_CODE) begin
					cur_x = cfg_padding;
					cur_y += cfg_font_height;
					fit_cursor();
				end else begin
					g = glyph_for(it.char_code);
					fw_eff = (cfg_font_width < MAX_FONT_WIDTH) ? cfg_font_width : MAX_FONT_WIDTH;
					mask = (fw_eff == 0) ? 0 : ((1 << fw_eff) - 1);
					fit_cursor();
					for (int r = 0; r < drawn_rows(); r++) begin
						d = '0;
						d.kind = KIND_DRAW;
						d.pixel_x = 12'(cur_x);
						d.pixel_y = 12'(cur_y + r);
						d.row_bits = 16'(int'(glyph_rows[g * MAX_FONT_HEIGHT + r]) & mask);
						d.draw_fg = it.fg_color;
						d.draw_bg = it.bg_color;
						pending_draws.push_back(d);
					end
					cur_x += cfg_font_width;
					fit_cursor();
				end
			end
			OP_SET: begin
				cur_x = int'(it.new_x);
				cur_y = int'(it.new_y);
				fit_cursor();
			end
			default: ;
		endcase
		if (pending_draws.size() > start) begin
			pending_draws[pending_draws.size() - 1].last = 1'b1;
		end
	endfunction

	// Operation with every field scrambled; callers set the fields that matter.
	function automatic in_item_t scrambled_item(input logic [1:0] op);
		in_item_t it;
		it.op = op;
		it.char_code = 8'($urandom);
		it.fg_color = 24'($urandom);
		it.bg_color = 24'($urandom);
		it.glyph_index = 8'($urandom);
		it.glyph_row = 5'($urandom);
		it.row_data = 16'($urandom);
		it.new_x = 12'($urandom);
		it.new_y = 12'($urandom);
		return it;
	endfunction

	// Offers one operation, holds it until accepted, then predicts its results.
	task automatic offer_op(input in_item_t it);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		render_op(it);
	endtask

	task automatic load_row(input int g, input int r, input logic [15:0] bits);
		in_item_t it;
		it = scrambled_item(OP_LOAD);
		it.glyph_index = 8'(g);
		it.glyph_row = 5'(r);
		it.row_data = bits;
		offer_op(it);
	endtask

	// A put first loads any glyph row it would draw that was never written.
	task automatic put_char(input logic [7:0] c, input logic [23:0] fg, input logic [23:0] bg);
		in_item_t it;
		int g;
		it = scrambled_item(OP_PUT);
		it.char_code = c;
		it.fg_color = fg;
		it.bg_color = bg;
		if (c != NEWLINE_CODE) begin
			g = glyph_for(c);
			for (int r = 0; r < drawn_rows(); r++) begin
				if (!row_loaded[g * MAX_FONT_HEIGHT + r]) begin
					load_row(g, r, 16'($urandom));
				end
			end
		end
		offer_op(it);
	endtask

	task automatic move_cursor(input int x, input int y);
		in_item_t it;
		it = scrambled_item(OP_SET);
		it.new_x = 12'(x);
		it.new_y = 12'(y);
		offer_op(it);
	endtask

	// Sender pauses until every owed transaction has arrived and the block settles.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Writes all six registers back to back while the block is idle.
	task automatic apply_config(input int gc, input int fw, input int fh,
			input int sw, input int sh, input int pad);
		logic [CFG_IDX_W-1:0] reg_order [6];
		int vals [6];
		reg_order = '{REG_GLYPH_COUNT, REG_FONT_WIDTH, REG_FONT_HEIGHT,
			REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_PADDING};
		vals = '{gc, fw, fh, sw, sh, pad};
		wait_quiet();
		for (int i = 0; i < 6; i++) begin
			wr_en <= 1'b1;
			wr_index <= reg_order[i];
			wr_data <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		cfg_glyph_count = gc & 'h1FF;
		cfg_font_width = fw & 'h1F;
		cfg_font_height = fh & 'h3F;
		cfg_screen_width = sw & 'hFFF;
		cfg_screen_height = sh & 'hFFF;
		cfg_padding = pad & 'hFF;
	endtask

	// Every operation and cursor edge case at the reset configuration.
	task automatic test_directed_ops();
		in_item_t it;
		it = scrambled_item(OP_UNUSED);
		offer_op(it);
		load_row(255, 31, 16'hFFFF);
		load_row(0, 0, 16'h0000);
		put_char(8'd0, 24'h000000, 24'hFFFFFF);
		put_char(8'd255, 24'hFFFFFF, 24'h000000);
		put_char(8'd255, 24'h123456, 24'h654321);
		put_char(NEWLINE_CODE, 24'h0, 24'h0);
		move_cursor(0, 0);
		move_cursor(4095, 4095);
		move_cursor(1006, 100);
		move_cursor(1005, 100);
		put_char(8'd255, 24'hFFFFFF, 24'h000000);
		move_cursor(500, 741);
		put_char(8'd0, 24'hAAAAAA, 24'h555555);
		put_char(NEWLINE_CODE, 24'h0, 24'h0);
		move_cursor(10, 742);
		put_char(8'd255, 24'h00FF00, 24'hFF00FF);
		move_cursor(11, 9);
		put_char(8'd0, 24'hFFFFFF, 24'hFFFFFF);
	endtask

	// Register extremes: tiny and huge screens, zero and oversized fonts.
	task automatic test_config_extremes();
		apply_config(1, 16, 1, 4095, 4095, 0);
		put_char(8'd200, 24'h0F0F0F, 24'hF0F0F0);
		move_cursor(4095, 0);
		move_cursor(0, 4095);
		put_char(NEWLINE_CODE, 24'h0, 24'h0);
		put_char(8'd7, 24'h010203, 24'h040506);

		apply_config(511, 31, 63, 4095, 4095, 255);
		put_char(8'd0, 24'hFFFFFF, 24'h000000);
		put_char(8'd0, 24'h000000, 24'hFFFFFF);
		put_char(NEWLINE_CODE, 24'h0, 24'h0);
		move_cursor(4000, 3700);
		put_char(8'd0, 24'h808080, 24'h7F7F7F);

		apply_config(0, 0, 0, 1, 1, 0);
		put_char(8'd33, 24'h111111, 24'h222222);
		put_char(NEWLINE_CODE, 24'h0, 24'h0);
		move_cursor(0, 0);

		apply_config(256, 1, 32, 300, 40, 255);
		put_char(8'd0, 24'h333333, 24'h444444);
		move_cursor(255, 255);
	endtask

	// Random traffic under one idle setting and one random mid-sized configuration.
	task automatic test_random_traffic(input int n_ops, input int gap_pct, input int stall_pct);
		in_item_t it;
		int pick;
		int done_ops;
		int x;
		int y;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		apply_config($urandom_range(1, 300), $urandom_range(1, 16), $urandom_range(1, 10),
			$urandom_range(16, 320), $urandom_range(16, 200), $urandom_range(0, 12));
		done_ops = 0;
		while (done_ops < n_ops) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				put_char(pick_code(), 24'($urandom), 24'($urandom));
			end else if (pick < 55) begin
				put_char(NEWLINE_CODE, 24'($urandom), 24'($urandom));
			end else if (pick < 70) begin
				if ($urandom_range(1) == 0) begin
					x = $urandom_range(0, 4095);
					y = $urandom_range(0, 4095);
				end else begin
					x = $urandom_range(0, cfg_screen_width + 4);
					y = $urandom_range(0, cfg_screen_height + 4);
				end
				move_cursor(x, y);
			end else if (pick < 85) begin
				load_row($urandom_range(0, 255), $urandom_range(0, 31), 16'($urandom));
			end else if (pick < 90) begin
				it = scrambled_item(OP_UNUSED);
				offer_op(it);
				done_ops--;
			end else begin
				put_char(pick_code(), 24'($urandom), 24'($urandom));
			end
			done_ops++;
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering puts.
	task automatic test_output_holdoff();
		wait_quiet();
		hold_req++;
		for (int k = 0; k < 10; k++) begin
			put_char(pick_code(), 24'($urandom), 24'($urandom));
		end
	endtask

	// Receiver stall: a requested hold-off first, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= REPORT_CAP) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		end
	endfunction

	// Compares each accepted transaction with the oldest owed one.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_draws.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_CAP) begin
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, out_data);
				end
			end else begin
				want = pending_draws.pop_front();
				check_field("kind", 24'(want.kind), 24'(out_data.kind));
				check_field("pixel_x", 24'(want.pixel_x), 24'(out_data.pixel_x));
				check_field("pixel_y", 24'(want.pixel_y), 24'(out_data.pixel_y));
				check_field("row_bits", 24'(want.row_bits), 24'(out_data.row_bits));
				check_field("draw_fg", want.draw_fg, out_data.draw_fg);
				check_field("draw_bg", want.draw_bg, out_data.draw_bg);
				check_field("last", 24'(want.last), 24'(out_data.last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 22;
		recv_stall_pct = 83;
		test_directed_ops();
		test_config_extremes();
		test_random_traffic(10, 22, 83);
		test_random_traffic(10, 83, 22);
		test_random_traffic(10, 0, 0);
		test_output_holdoff();
		wait_quiet();
		if (err_count == 0 && pending_draws.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
